FILE: src/rtbrs_pkg.sv
// Shared types for the rank-then-radix sorter.
// Request payload structs and the per-cell data struct; no dependencies.
`default_nettype none
package rtbrs_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned RANK_W = 6;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_in;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic [RANK_W-1:0]        rank;
    logic                     overflow;
    logic                     last_out;
  } out_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
  } cell_t;

endpackage
`default_nettype wire

FILE: src/rtbrs_cell.sv
// One cell of the sorting chain: holds one value and its valid bit.
// Depends on rtbrs_pkg for cell_t and DATA_W.
`default_nettype none
module rtbrs_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               ins_en,
  input  logic                               shl_en,
  input  logic signed [rtbrs_pkg::DATA_W-1:0] ins_value,
  input  rtbrs_pkg::cell_t                   left,
  input  logic                               left_mv,
  input  rtbrs_pkg::cell_t                   right,
  output rtbrs_pkg::cell_t                   q,
  output logic                               mv
);
  import rtbrs_pkg::*;

  logic                     valid_r;
  logic signed [DATA_W-1:0] value_r;

  assign q.valid = valid_r;
  assign q.value = value_r;

  // A cell moves when it is empty or holds a value greater than the new one,
  // so equal values stay ahead of the newcomer and load order is kept.
  assign mv = !valid_r || ($signed(value_r) > $signed(ins_value));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ins_en) begin
      if (mv) begin
        if (left_mv) begin
          value_r <= left.value;
          valid_r <= left.valid;
        end else begin
          value_r <= ins_value;
          valid_r <= 1'b1;
        end
      end
    end else if (shl_en) begin
      valid_r <= right.valid;
      value_r <= right.value;
    end
  end

endmodule
`default_nettype wire

FILE: src/rtbrs_chain.sv
// Row of sorting cells kept in ascending order, with insert and shift-out.
// Depends on rtbrs_pkg and rtbrs_cell.
`default_nettype none
module rtbrs_chain #(
  parameter int unsigned N_CELLS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               ins_en,
  input  logic                               shl_en,
  input  logic signed [rtbrs_pkg::DATA_W-1:0] ins_value,
  output rtbrs_pkg::cell_t                   head
);
  import rtbrs_pkg::*;

  cell_t q [N_CELLS];
  logic  mv [N_CELLS];

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    cell_t left_c;
    cell_t right_c;
    logic  left_mv_c;

    if (i == 0) begin : g_first
      assign left_c    = '0;
      assign left_mv_c = 1'b0;
    end else begin : g_mid
      assign left_c    = q[i-1];
      assign left_mv_c = mv[i-1];
    end

    if (i == N_CELLS - 1) begin : g_end
      assign right_c = '0;
    end else begin : g_inner
      assign right_c = q[i+1];
    end

    rtbrs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ins_en    (ins_en),
      .shl_en    (shl_en),
      .ins_value (ins_value),
      .left      (left_c),
      .left_mv   (left_mv_c),
      .right     (right_c),
      .q         (q[i]),
      .mv        (mv[i])
    );
  end

  assign head = q[0];

endmodule
`default_nettype wire

FILE: src/rank_then_binary_radix_sort.sv
// Sorter top level. Loading takes one request per cycle while busy is low; each value is
// inserted into its sorted place in the cell row as it arrives.
// After the edge that takes the request marked last, busy is high while the n stored
// values are emitted, and the head cell is shifted out once per cycle; each result
// is registered and shows in the cycle after its shift.
// Synchronous active-low reset empties the row and clears count and flag.
`default_nettype none
module rank_then_binary_radix_sort #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  rtbrs_pkg::in_t   in_data,
  output logic             out_valid,
  output rtbrs_pkg::out_t  out_data
);
  import rtbrs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IW = $clog2(MAX_ITEMS);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic          state_r;
  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic [IW-1:0] k_r;
  logic signed [DATA_W-1:0] prev_value_r;
  logic [IW-1:0] prev_rank_r;
  logic          out_valid_r;
  out_t          out_r;

  logic          accept;
  logic          full;
  logic          ins_en;
  logic          shl_en;
  cell_t         head;
  logic [CW-1:0] k_ext_p1;
  logic          emit_last;
  logic [IW-1:0] cur_rank;

  assign busy   = (state_r == ST_EMIT);
  assign accept = start && !busy;
  assign full   = (count_r == CW'(MAX_ITEMS));
  assign ins_en = accept && !full;
  assign shl_en = busy;

  rtbrs_chain #(.N_CELLS(MAX_ITEMS)) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ins_en    (ins_en),
    .shl_en    (shl_en),
    .ins_value (in_data.value),
    .head      (head)
  );

  assign k_ext_p1  = CW'(k_r) + CW'(1);
  assign emit_last = (k_ext_p1 == count_r);

  // Equal values share the rank of the first of their run.
  assign cur_rank  = ((k_r != '0) && (head.value == prev_value_r)) ? prev_rank_r : k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_LOAD: begin
          if (accept) begin
            if (full) begin
              ovf_r <= 1'b1;
            end else begin
              count_r <= count_r + CW'(1);
            end
            if (in_data.last_in) begin
              state_r <= ST_EMIT;
              k_r     <= '0;
            end
          end
        end
        ST_EMIT: begin
          out_valid_r <= 1'b1;
          k_r         <= k_r + IW'(1);
          if (emit_last) begin
            state_r <= ST_LOAD;
            count_r <= '0;
            ovf_r   <= 1'b0;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      out_r.sorted_value <= head.value;
      out_r.rank         <= RANK_W'(cur_rank);
      out_r.overflow     <= ovf_r;
      out_r.last_out     <= emit_last;
      prev_value_r       <= head.value;
      prev_rank_r        <= cur_rank;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: src/rtbrs_checker.sv
// Port-level checks for the sorter, bound to the top level.
// Depends on rtbrs_pkg for the request structs.
`default_nettype none
module rtbrs_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input rtbrs_pkg::in_t  in_data,
  input logic            out_valid,
  input rtbrs_pkg::out_t out_data
);
  import rtbrs_pkg::*;

  // Results only come out of an emission phase.
  a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe outside emission");

  // The final result closes the emission phase.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_out) |-> !busy)
    else $error("busy still high after final result");

  // A request marked last starts emission.
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last_in) |=> busy)
    else $error("last request did not start emission");

  // The first result follows in the cycle after busy rises.
  a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |=> out_valid)
    else $error("no result after emission began");

endmodule

bind rank_then_binary_radix_sort rtbrs_checker u_rtbrs_checker (.*);
`default_nettype wire
